FILE: src/scpa_pkg.sv
// Shared types and constants for the size-class pool allocator.
// Used by scpa_ctrl, scpa_dp and size_class_pool_allocator; no dependencies.
package scpa_pkg;

  // Field widths fixed by the interface
  localparam int REQ_W   = 16;
  localparam int OFF_W   = 17;
  localparam int CFG_W   = 9;
  localparam int CLS_W   = 2;
  localparam int STAT_W  = 2;

  // Size classes: MIN_BLOCK_BYTES << class
  localparam int NUM_CLASSES     = 4;
  localparam int MIN_BLOCK_LG    = 5;
  localparam int MIN_BLOCK_BYTES = 1 << MIN_BLOCK_LG;
  localparam int MAX_REQ_BYTES   = MIN_BLOCK_BYTES << (NUM_CLASSES - 1);

  // Occupancy memory word
  localparam int WORD_W  = 64;
  localparam int WORD_LG = 6;

  // Block count register reset value
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // Action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Status codes
  typedef logic [STAT_W-1:0] status_t;
  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_NO_ALLOC = 2'd1;
  localparam status_t STAT_NO_FREE  = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A_SETUP,
    ST_A_RD,
    ST_A_CHK,
    ST_F_CLS,
    ST_F_RD,
    ST_F_CHK,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic alloc_setup;
    logic free_setup;
    logic mem_rd;
    logic alloc_chk;
    logic next_word;
    logic free_chk;
    logic publish;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic alloc_bad;
    logic free_bad;
    logic found;
    logic last_word;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: src/size_class_pool_allocator.sv
// Size-class pool allocator: allocate/free of 32..256 byte blocks.
// Steps: setup decodes the accepted beat, then the occupancy word is read and checked; an
// allocate repeats read and check per extra 64-block word, and a request rejected at setup
// skips the read. One request at a time: a new beat is taken only after the last result is
// published, and each word is read, then checked, on the single occupancy memory port.
// Reset: all blocks free at once through per-word valid flags, blocks_per_class = 256.
module size_class_pool_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [scpa_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [scpa_pkg::REQ_W-1:0]    in_req_size,
  input  logic [scpa_pkg::OFF_W-1:0]    in_free_offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [scpa_pkg::STAT_W-1:0]   out_status,
  output logic [scpa_pkg::OFF_W-1:0]    out_block_offset,
  output logic [scpa_pkg::CLS_W-1:0]    out_size_class
);

  scpa_pkg::ctl_cmd_t cmd;
  scpa_pkg::dp_sts_t  sts;

  // Controller
  scpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  scpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_req_size      (in_req_size),
    .in_free_offset   (in_free_offset),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_block_offset (out_block_offset),
    .out_size_class   (out_size_class),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

FILE: src/scpa_ctrl.sv
// Sequencing state machine for the size-class pool allocator.
// Depends on scpa_pkg; drives commands into scpa_dp and the input stall.
module scpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_action,
  output logic               in_stall,
  input  scpa_pkg::dp_sts_t  sts,
  output scpa_pkg::ctl_cmd_t cmd
);

  scpa_pkg::state_t state_r;
  scpa_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scpa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      scpa_pkg::ST_IDLE: begin
        // no beat is taken while reset is held
        in_stall = !rst_n;
        if (in_valid && rst_n) begin
          cmd.load = 1'b1;
          state_nxt = (in_action == scpa_pkg::ACT_FREE) ? scpa_pkg::ST_F_CLS
                                                         : scpa_pkg::ST_A_SETUP;
        end
      end
      scpa_pkg::ST_A_SETUP: begin
        cmd.alloc_setup = 1'b1;
        state_nxt = sts.alloc_bad ? scpa_pkg::ST_DONE : scpa_pkg::ST_A_RD;
      end
      scpa_pkg::ST_A_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt = scpa_pkg::ST_A_CHK;
      end
      scpa_pkg::ST_A_CHK: begin
        cmd.alloc_chk = 1'b1;
        if (sts.found || sts.last_word) begin
          state_nxt = scpa_pkg::ST_DONE;
        end else begin
          cmd.next_word = 1'b1;
          state_nxt = scpa_pkg::ST_A_RD;
        end
      end
      scpa_pkg::ST_F_CLS: begin
        cmd.free_setup = 1'b1;
        state_nxt = sts.free_bad ? scpa_pkg::ST_DONE : scpa_pkg::ST_F_RD;
      end
      scpa_pkg::ST_F_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt = scpa_pkg::ST_F_CHK;
      end
      scpa_pkg::ST_F_CHK: begin
        cmd.free_chk = 1'b1;
        state_nxt = scpa_pkg::ST_DONE;
      end
      scpa_pkg::ST_DONE: begin
        // wait for the output register to have room
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt = scpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scpa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/scpa_dp.sv
// Datapath of the size-class pool allocator: count register, region math,
// occupancy memory with per-word valid flags, and the output register.
// Depends on scpa_pkg; commanded by scpa_ctrl.
module scpa_dp #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [scpa_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic [scpa_pkg::REQ_W-1:0]    in_req_size,
  input  logic [scpa_pkg::OFF_W-1:0]    in_free_offset,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [scpa_pkg::STAT_W-1:0]   out_status,
  output logic [scpa_pkg::OFF_W-1:0]    out_block_offset,
  output logic [scpa_pkg::CLS_W-1:0]    out_size_class,
  input  scpa_pkg::ctl_cmd_t            cmd,
  output scpa_pkg::dp_sts_t             sts
);

  // Derived sizes
  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int AW    = CW + scpa_pkg::MIN_BLOCK_LG + scpa_pkg::NUM_CLASSES;
  localparam int EW    = (AW > scpa_pkg::OFF_W) ? AW : scpa_pkg::OFF_W;
  localparam int WPC   = (MAX_BLOCKS + scpa_pkg::WORD_W - 1) / scpa_pkg::WORD_W;
  localparam int WW    = (WPC > 1) ? $clog2(WPC) : 1;
  localparam int DEPTH = scpa_pkg::NUM_CLASSES * WPC;
  localparam int DW    = $clog2(DEPTH);

  // Configuration register
  logic [scpa_pkg::CFG_W-1:0] count_r;
  logic [CW-1:0]              ac;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= scpa_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // Saturate to the pool capacity
  assign ac = (32'(count_r) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(count_r);

  // Region bases and ends: shifted count differences, no multiplier
  logic [EW-1:0] base_w [scpa_pkg::NUM_CLASSES];
  logic [EW-1:0] end_w  [scpa_pkg::NUM_CLASSES];

  always_comb begin
    for (int k = 0; k < scpa_pkg::NUM_CLASSES; k++) begin
      end_w[k] = (EW'(ac) << (scpa_pkg::MIN_BLOCK_LG + k + 1))
               - (EW'(ac) << scpa_pkg::MIN_BLOCK_LG);
      base_w[k] = (k == 0) ? '0 : end_w[(k == 0) ? 0 : k - 1];
    end
  end

  // Captured request
  logic [scpa_pkg::REQ_W-1:0] req_r;
  logic [scpa_pkg::OFF_W-1:0] off_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_size;
      off_r <= in_free_offset;
    end
  end

  // Allocate: smallest fitting class
  logic [scpa_pkg::CLS_W-1:0] acls;
  logic                       afit;

  always_comb begin
    acls = '0;
    for (int k = scpa_pkg::NUM_CLASSES - 1; k >= 0; k--) begin
      if (32'(req_r) <= (scpa_pkg::MIN_BLOCK_BYTES << k)) begin
        acls = scpa_pkg::CLS_W'(k);
      end
    end
    afit = (32'(req_r) <= scpa_pkg::MAX_REQ_BYTES);
  end

  // Free: region lookup, alignment and block index
  logic [EW-1:0]              off_e;
  logic [EW-1:0]              rel;
  logic [EW-1:0]              fidx;
  logic [scpa_pkg::CLS_W-1:0] fcls;
  logic                       fhit;
  logic                       faligned;

  assign off_e = EW'(off_r);

  always_comb begin
    fhit     = 1'b0;
    faligned = 1'b0;
    fcls     = '0;
    rel      = '0;
    fidx     = '0;
    for (int k = 0; k < scpa_pkg::NUM_CLASSES; k++) begin
      if (!fhit && off_e < end_w[k]) begin
        fhit     = 1'b1;
        fcls     = scpa_pkg::CLS_W'(k);
        rel      = off_e - base_w[k];
        faligned = (rel & ((EW'(1) << (scpa_pkg::MIN_BLOCK_LG + k)) - EW'(1))) == '0;
        fidx     = rel >> (scpa_pkg::MIN_BLOCK_LG + k);
      end
    end
  end

  // Walk state
  logic [scpa_pkg::CLS_W-1:0]   cls_r;
  logic [WW-1:0]                sel_r;
  logic [scpa_pkg::WORD_LG-1:0] bit_r;

  // Occupancy memory, valid flag per word so reset frees everything at once
  logic [scpa_pkg::WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            vld_r;
  logic [scpa_pkg::WORD_W-1:0] rdata_r;
  logic                        rvld_r;
  logic [DW-1:0]               addr;
  logic                        wr_en;
  logic [scpa_pkg::WORD_W-1:0] wdata;
  logic [scpa_pkg::WORD_W-1:0] word;

  assign addr = DW'(32'(cls_r) * WPC + 32'(sel_r));
  assign word = rvld_r ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rdata_r <= mem[addr];
      rvld_r  <= vld_r[addr];
    end
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[addr] <= 1'b1;
    end
  end

  // Lowest free block in the current word, blocks past the count masked off
  logic [scpa_pkg::WORD_W-1:0]  mask;
  logic [scpa_pkg::WORD_W-1:0]  avail;
  logic [scpa_pkg::WORD_W-1:0]  lowbit;
  logic [scpa_pkg::WORD_LG-1:0] lowidx;
  logic [31:0]                  lim;

  always_comb begin
    lim = 32'(ac) - (32'(sel_r) << scpa_pkg::WORD_LG);
    for (int b = 0; b < scpa_pkg::WORD_W; b++) begin
      mask[b] = (32'(b) < lim);
    end
    avail  = ~word & mask;
    lowbit = avail & (~avail + 64'd1);
    lowidx = '0;
    for (int b = 0; b < scpa_pkg::WORD_W; b++) begin
      if (lowbit[b]) begin
        lowidx = lowidx | scpa_pkg::WORD_LG'(b);
      end
    end
  end

  logic          found;
  logic          last_word;
  logic          occupied;
  logic [3:0]    shamt;
  logic [EW-1:0] a_off;

  assign found     = |avail;
  assign last_word = ((32'(sel_r) + 32'd1) << scpa_pkg::WORD_LG) >= 32'(ac);
  assign occupied  = word[bit_r];
  assign shamt     = 4'(scpa_pkg::MIN_BLOCK_LG) + 4'(cls_r);
  assign a_off     = base_w[cls_r] + (EW'({sel_r, lowidx}) << shamt);

  // Memory write: set the found bit, or clear the freed one
  always_comb begin
    wr_en = 1'b0;
    wdata = word;
    if (cmd.alloc_chk && found) begin
      wr_en = 1'b1;
      wdata = word | lowbit;
    end else if (cmd.free_chk && occupied) begin
      wr_en = 1'b1;
      wdata = word & ~(64'd1 << bit_r);
    end
  end

  // Result registers
  scpa_pkg::status_t          res_status_r;
  logic [scpa_pkg::OFF_W-1:0] res_off_r;
  logic [scpa_pkg::CLS_W-1:0] res_cls_r;

  always_ff @(posedge clk) begin
    if (cmd.alloc_setup) begin
      cls_r        <= afit ? acls : '0;
      sel_r        <= '0;
      res_status_r <= scpa_pkg::STAT_NO_ALLOC;
      res_off_r    <= '0;
      res_cls_r    <= afit ? acls : '0;
    end
    if (cmd.next_word) begin
      sel_r <= sel_r + WW'(1);
    end
    if (cmd.alloc_chk && found) begin
      res_status_r <= scpa_pkg::STAT_OK;
      res_off_r    <= scpa_pkg::OFF_W'(a_off);
    end
    if (cmd.free_setup) begin
      cls_r        <= fcls;
      sel_r        <= WW'(fidx >> scpa_pkg::WORD_LG);
      bit_r        <= fidx[scpa_pkg::WORD_LG-1:0];
      res_status_r <= scpa_pkg::STAT_NO_FREE;
      res_off_r    <= off_r;
      res_cls_r    <= fcls;
    end
    if (cmd.free_chk && occupied) begin
      res_status_r <= scpa_pkg::STAT_OK;
    end
  end

  // Output register
  logic                        out_valid_r;
  scpa_pkg::status_t           out_status_r;
  logic [scpa_pkg::OFF_W-1:0]  out_off_r;
  logic [scpa_pkg::CLS_W-1:0]  out_cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_status_r <= res_status_r;
      out_off_r    <= res_off_r;
      out_cls_r    <= res_cls_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block_offset = out_off_r;
  assign out_size_class   = out_cls_r;

  // Status back to the controller
  assign sts.alloc_bad = !afit || (ac == '0);
  assign sts.free_bad  = !fhit || !faligned;
  assign sts.found     = found;
  assign sts.last_word = last_word;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for size_class_pool_allocator: allocate/free traffic against a
// cycle-free predictor of the occupancy maps, across several block-count settings.
// Depends on scpa_pkg and the size_class_pool_allocator RTL.
module testbench;

  localparam int POOL_BLOCKS = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 10;

  typedef struct packed {
    logic                       act;
    logic [scpa_pkg::REQ_W-1:0] req;
    logic [scpa_pkg::OFF_W-1:0] off;
  } pool_op_t;

  typedef struct packed {
    scpa_pkg::status_t          status;
    logic [scpa_pkg::OFF_W-1:0] blk_off;
    logic [scpa_pkg::CLS_W-1:0] cls;
  } pool_resp_t;

  logic                        clk            = 1'b0;
  logic                        rst_n          = 1'b0;
  logic                        cfg_wr_en      = 1'b0;
  logic [scpa_pkg::CFG_W-1:0]  cfg_wr_data    = '0;
  logic                        in_valid       = 1'b0;
  logic                        in_stall;
  logic                        in_action      = scpa_pkg::ACT_ALLOC;
  logic [scpa_pkg::REQ_W-1:0]  in_req_size    = '0;
  logic [scpa_pkg::OFF_W-1:0]  in_free_offset = '0;
  logic                        out_valid;
  logic                        out_stall      = 1'b0;
  logic [scpa_pkg::STAT_W-1:0] out_status;
  logic [scpa_pkg::OFF_W-1:0]  out_block_offset;
  logic [scpa_pkg::CLS_W-1:0]  out_size_class;

  // Predictor state: one busy bit per block and class, plus the count register
  bit [POOL_BLOCKS-1:0]       block_busy [scpa_pkg::NUM_CLASSES];
  bit [scpa_pkg::CFG_W-1:0]   cfg_blocks = scpa_pkg::CFG_RESET;

  pool_op_t   op_backlog[$];
  pool_resp_t resp_expected[$];
  pool_op_t   head_op;
  pool_resp_t want;

  int unsigned ops_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  bit          hold_on      = 1'b0;

  int unsigned phase_blocks [NUM_PHASES] = '{8, 1, 256, 0, 511, 65, 3, 300, 100, 255};
  int unsigned phase_ops    [NUM_PHASES] = '{90, 30, 200, 20, 80, 80, 40, 60, 80, 70};

  size_class_pool_allocator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_req_size     (in_req_size),
    .in_free_offset  (in_free_offset),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_block_offset(out_block_offset),
    .out_size_class  (out_size_class)
  );

  always #5 clk = ~clk;

  // Byte offset where class cls starts, for a given live block count
  function automatic int unsigned region_base(int unsigned cls, int unsigned count);
    return count * scpa_pkg::MIN_BLOCK_BYTES * ((1 << cls) - 1);
  endfunction

  // Work out the result of one accepted beat and update the occupancy maps
  function automatic void predict_pool_op(logic act, logic [scpa_pkg::REQ_W-1:0] req,
                                          logic [scpa_pkg::OFF_W-1:0] off);
    pool_resp_t  r;
    int unsigned count, bytes, base_b, rel, idx;
    int unsigned c;
    count     = (cfg_blocks > POOL_BLOCKS) ? POOL_BLOCKS : cfg_blocks;
    r.status  = scpa_pkg::STAT_NO_ALLOC;
    r.blk_off = '0;
    r.cls     = '0;
    if (act == scpa_pkg::ACT_ALLOC) begin
      c = 0;
      while (c < scpa_pkg::NUM_CLASSES && req > (scpa_pkg::MIN_BLOCK_BYTES << c)) c++;
      if (c < scpa_pkg::NUM_CLASSES) begin
        r.cls = scpa_pkg::CLS_W'(c);
        bytes = scpa_pkg::MIN_BLOCK_BYTES << c;
        for (idx = 0; idx < count; idx++) begin
          if (!block_busy[c][idx]) begin
            block_busy[c][idx] = 1'b1;
            r.blk_off = scpa_pkg::OFF_W'(region_base(c, count) + idx * bytes);
            r.status  = scpa_pkg::STAT_OK;
            break;
          end
        end
      end
    end else begin
      r.status  = scpa_pkg::STAT_NO_FREE;
      r.blk_off = off;
      for (c = 0; c < scpa_pkg::NUM_CLASSES; c++) begin
        bytes  = scpa_pkg::MIN_BLOCK_BYTES << c;
        base_b = region_base(c, count);
        if (off >= base_b && off < base_b + count * bytes) begin
          r.cls = scpa_pkg::CLS_W'(c);
          rel   = off - base_b;
          if (rel % bytes == 0) begin
            idx = rel / bytes;
            if (idx < count && block_busy[c][idx]) begin
              block_busy[c][idx] = 1'b0;
              r.status = scpa_pkg::STAT_OK;
            end
          end
          break;
        end
      end
    end
    resp_expected = {resp_expected, r};
  endfunction

  // Mostly well-formed traffic: allocs of every class and frees of low, likely live blocks
  function automatic pool_op_t make_random_op(int unsigned count, int unsigned alloc_pct);
    pool_op_t    op;
    int unsigned pick, cls, bytes, lo, span, idx;
    op.act = scpa_pkg::ACT_ALLOC;
    op.req = scpa_pkg::REQ_W'($urandom());
    op.off = scpa_pkg::OFF_W'($urandom());
    pick   = $urandom_range(99);
    cls    = $urandom_range(scpa_pkg::NUM_CLASSES - 1);
    bytes  = scpa_pkg::MIN_BLOCK_BYTES << cls;
    span   = (count < 24) ? count : 24;
    idx    = (span == 0) ? 0 : $urandom_range(span - 1);
    if (pick < alloc_pct) begin
      lo = (cls == 0) ? 0 : (bytes >> 1) + 1;
      case ($urandom_range(19))
        0:       op.req = scpa_pkg::REQ_W'($urandom_range(65535,
                                                          scpa_pkg::MAX_REQ_BYTES + 1));
        1:       op.req = scpa_pkg::REQ_W'(bytes);
        default: op.req = scpa_pkg::REQ_W'($urandom_range(bytes, lo));
      endcase
    end else if (pick < 92 && count != 0) begin
      op.act = scpa_pkg::ACT_FREE;
      op.off = scpa_pkg::OFF_W'(region_base(cls, count) + idx * bytes);
    end else begin
      // noise: anywhere in the offset space, or just off a block boundary
      op.act = scpa_pkg::ACT_FREE;
      if ($urandom_range(1) == 0)
        op.off = scpa_pkg::OFF_W'(region_base(cls, count) + idx * bytes
                                  + $urandom_range(bytes - 1, 1));
    end
    return op;
  endfunction

  function automatic void add_op(logic act, int unsigned req, int unsigned off);
    pool_op_t op;
    op.act = act;
    op.req = scpa_pkg::REQ_W'(req);
    op.off = scpa_pkg::OFF_W'(off);
    op_backlog = {op_backlog, op};
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  // Nothing queued, nothing offered, nothing outstanding
  task automatic wait_for_idle();
    do @(negedge clk);
    while (op_backlog.size() != 0 || in_valid || resp_expected.size() != 0);
  endtask

  task automatic set_block_count(input int unsigned value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= scpa_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_blocks  = scpa_pkg::CFG_W'(value);
  endtask

  // Driver: predict on each accepted beat, then load the next one or idle
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      predict_pool_op(in_action, in_req_size, in_free_offset);
      ops_accepted++;
    end
    if (rst_n && (!in_valid || !in_stall)) begin
      if (op_backlog.size() != 0 &&
          ((ops_accepted >= 450 && ops_accepted < 560) || $urandom_range(99) >= 33)) begin
        head_op        = op_backlog.pop_front();
        in_valid       <= 1'b1;
        in_action      <= head_op.act;
        in_req_size    <= head_op.req;
        in_free_offset <= head_op.off;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off, counted in cycles, so the block backs up into its input
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      if (hold_left == 0) hold_on <= 1'b0;
    end else if (!hold_done && results_seen >= 160) begin
      hold_done = 1'b1;
      hold_left = 80;
      hold_on   <= 1'b1;
    end
  end

  // Monitor: check each result beat, then pick this cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (resp_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected beat status %0d offset %0d class %0d",
                                  out_status, out_block_offset, out_size_class));
      end else begin
        want = resp_expected.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_block_offset !== want.blk_off)
          report_mismatch($sformatf("offset %0d, want %0d", out_block_offset, want.blk_off));
        if (out_size_class !== want.cls)
          report_mismatch($sformatf("class %0d, want %0d", out_size_class, want.cls));
      end
    end
    out_stall <= hold_on ||
                 (!(results_seen >= 450 && results_seen < 560) && ($urandom_range(99) < 33));
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass at the reset count of 256: size boundaries, oversize, bad frees
    add_op(scpa_pkg::ACT_ALLOC, 0, 0);
    add_op(scpa_pkg::ACT_ALLOC, 1, 0);
    add_op(scpa_pkg::ACT_ALLOC, 32, 0);
    add_op(scpa_pkg::ACT_ALLOC, 33, 0);
    add_op(scpa_pkg::ACT_ALLOC, 64, 0);
    add_op(scpa_pkg::ACT_ALLOC, 65, 0);
    add_op(scpa_pkg::ACT_ALLOC, 128, 0);
    add_op(scpa_pkg::ACT_ALLOC, 129, 131071);
    add_op(scpa_pkg::ACT_ALLOC, 256, 0);
    add_op(scpa_pkg::ACT_ALLOC, 257, 0);
    add_op(scpa_pkg::ACT_ALLOC, 65535, 0);
    add_op(scpa_pkg::ACT_FREE, 65535, 0);
    add_op(scpa_pkg::ACT_FREE, 0, 0);
    add_op(scpa_pkg::ACT_FREE, 0, 1);
    add_op(scpa_pkg::ACT_FREE, 0, 131071);
    add_op(scpa_pkg::ACT_FREE, 0, 122880);
    add_op(scpa_pkg::ACT_FREE, 0, 122879);
    add_op(scpa_pkg::ACT_FREE, 0, 57344);
    add_op(scpa_pkg::ACT_FREE, 0, 8256);
    add_op(scpa_pkg::ACT_FREE, 0, 24576);
    add_op(scpa_pkg::ACT_ALLOC, 16, 0);
    add_op(scpa_pkg::ACT_FREE, 0, 32);

    // Random phases, each under its own block count; live bits carry across
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_idle();
      set_block_count(phase_blocks[p]);
      for (int n = 0; n < phase_ops[p]; n++)
        op_backlog = {op_backlog,
                      make_random_op((phase_blocks[p] > POOL_BLOCKS) ? POOL_BLOCKS
                                     : phase_blocks[p],
                                     (phase_blocks[p] == 256) ? 80 : 50)};
    end

    wait_for_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
